// ===== design/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the min-heap priority queue core: word types, action and status
// codes, and the control word that the top level sends to every cell.
// No dependencies.
package mhpq_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  localparam int unsigned FIELD_WIDTH = 32;
  localparam int unsigned COUNT_WIDTH = 11;

  typedef struct packed {
    logic [1:0]                    action;
    logic signed [FIELD_WIDTH-1:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] min_value;
    logic [COUNT_WIDTH-1:0]        entry_count;
    logic [1:0]                    status;
  } result_word_t;

  // Per-cycle control broadcast to the cell row.
  typedef struct packed {
    logic ins_commit;  // insert the operand at its sorted place
    logic del_commit;  // close the gap left by the first matching entry
    logic scan_clear;  // clear the match flags
    logic scan_run;    // ripple the match flags one cell to the right
  } cell_ctrl_t;

endpackage

// ===== design/min_heap_priority_queue_core.sv =====
`timescale 1ns / 1ps
// Priority queue core with min-heap semantics, built as a row of sorted cells.
// Depends on mhpq_pkg and mhpq_cell.
//
// Use: drive cmd (action, value) and pulse start while busy is low; the word
// is taken at that edge. Exactly one result word follows on result, marked by
// done for a single cycle; it cannot be held off, so capture it then.
// result carries the minimum after the operation (zero when empty), the entry
// count and a status: ok, full on insert, value not found, query on empty.
// Steps: insert, query and no-op pass from accept through an exec state and
// a report state, after which done rises; delete runs a match scan first,
// then exec and report. In the scan a found flag moves one cell per cycle
// along the row and must cross all CAPACITY cells. Insert places the operand
// and shifts the tail in the exec state, every cell comparing in parallel.
// A new word may be started in the cycle that done is high.
// The row is kept sorted, so cell 0 holds the minimum; the heap's observable
// answers (minimum, count, found or not) are the same.
// Reset clears the count and the control state; cell contents are left as
// they are and only cells below the count are ever looked at.
module min_heap_priority_queue_core #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  mhpq_pkg::cmd_word_t    cmd,
  output logic                   busy,
  output logic                   done,
  output mhpq_pkg::result_word_t result
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_EXEC   = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [1:0]                    op_action;   // latched action
  logic signed [VALUE_WIDTH-1:0] operand;     // latched operand
  logic [63:0]                   raw_ext;
  logic [CW-1:0]                 count, count_next;
  logic [IW-1:0]                 scan_idx;
  logic [1:0]                    status_q, status_next;
  logic                          accept;
  logic                          is_full;
  logic                          found;
  mhpq_pkg::cell_ctrl_t          ctrl;

  logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic                          cell_gt    [CAPACITY];
  logic                          cell_hit   [CAPACITY];
  logic signed [63:0]            root_ext;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign is_full = (count == CW'(CAPACITY));
  // Match flag has crossed the whole row by the last cell.
  assign found   = cell_hit[CAPACITY-1];

  // Field is taken as raw bits, then read as a VALUE_WIDTH signed number.
  assign raw_ext = {32'd0, cmd.value};

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (mhpq_pkg::action_t'(cmd.action) == mhpq_pkg::ACT_DELETE)
                       ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (scan_idx == IW'(CAPACITY - 1)) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC:   state_next = S_REPORT;
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl            = '0;
    ctrl.scan_clear = accept;
    ctrl.scan_run   = (state == S_SCAN);
    count_next      = count;
    status_next     = status_q;
    if (state == S_EXEC) begin
      status_next = mhpq_pkg::ST_OK;
      case (mhpq_pkg::action_t'(op_action))
        mhpq_pkg::ACT_INSERT: begin
          if (is_full) begin
            status_next = mhpq_pkg::ST_FULL;
          end else begin
            ctrl.ins_commit = 1'b1;
            count_next      = count + CW'(1);
          end
        end
        mhpq_pkg::ACT_DELETE: begin
          if (found) begin
            ctrl.del_commit = 1'b1;
            count_next      = count - CW'(1);
          end else begin
            status_next = mhpq_pkg::ST_NOT_FOUND;
          end
        end
        mhpq_pkg::ACT_QUERY: begin
          if (count == '0) begin
            status_next = mhpq_pkg::ST_EMPTY;
          end
        end
        default: status_next = mhpq_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      scan_idx <= '0;
      status_q <= mhpq_pkg::ST_OK;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      status_q <= status_next;
      done     <= (state == S_REPORT);
      if (accept) begin
        scan_idx <= '0;
      end else if (state == S_SCAN) begin
        scan_idx <= scan_idx + IW'(1);
      end
    end
  end

  // Operand and action hold for the whole operation.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_action <= cmd.action;
      operand   <= raw_ext[VALUE_WIDTH-1:0];
    end
  end

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_value;
    logic signed [VALUE_WIDTH-1:0] right_value;
    logic                          left_gt;
    logic                          left_hit;
    logic                          occupied;

    assign occupied = (count > CW'(i));

    if (i == 0) begin : g_head
      assign left_value = cell_value[0];
      assign left_gt    = 1'b0;
      assign left_hit   = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
      assign left_hit   = cell_hit[i-1];
    end

    // Tail cell takes its own value on delete; it falls outside the count.
    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    mhpq_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .operand    (operand),
      .occupied   (occupied),
      .left_value (left_value),
      .left_gt    (left_gt),
      .left_hit   (left_hit),
      .right_value(right_value),
      .value      (cell_value[i]),
      .gt         (cell_gt[i]),
      .hit        (cell_hit[i])
    );
  end

  // ---------------------------------------------------------------- result
  // Minimum sits in cell 0; widen with sign, then keep the low field bits.
  assign root_ext = 64'(cell_value[0]);

  always_ff @(posedge clk) begin
    if (state == S_REPORT) begin
      result.min_value   <= (count != '0) ? root_ext[mhpq_pkg::FIELD_WIDTH-1:0] : '0;
      result.entry_count <= mhpq_pkg::COUNT_WIDTH'(count);
      result.status      <= status_q;
    end
  end

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_after_report: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(state == S_REPORT))
    else $error("result strobe without a report cycle");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && op_action == mhpq_pkg::ACT_INSERT && !is_full)
      |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count");

  a_delete_scan_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && op_action == mhpq_pkg::ACT_DELETE)
      |-> $past(state == S_SCAN))
    else $error("delete committed without a full scan");

  a_count_steady: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_REPORT) |=> $stable(count))
    else $error("count moved outside the commit cycle");

endmodule

// ===== design/mhpq_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted row: holds one entry and a rippling match flag.
// Depends on mhpq_pkg.
module mhpq_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mhpq_pkg::cell_ctrl_t          ctrl,
  input  logic signed [VALUE_WIDTH-1:0] operand,
  input  logic                          occupied,
  input  logic signed [VALUE_WIDTH-1:0] left_value,
  input  logic                          left_gt,
  input  logic                          left_hit,
  input  logic signed [VALUE_WIDTH-1:0] right_value,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic                          gt,
  output logic                          hit
);

  logic ge;
  logic eq;
  logic signed [VALUE_WIDTH-1:0] value_next;
  logic hit_next;

  // Empty cells count as larger than anything: keeps the flags monotone.
  assign gt = !occupied || (value > operand);
  assign ge = !occupied || (value >= operand);
  assign eq = occupied && (value == operand);

  always_comb begin
    value_next = value;
    if (ctrl.ins_commit) begin
      if (left_gt) begin
        value_next = left_value;
      end else if (gt) begin
        value_next = operand;
      end
    end else if (ctrl.del_commit) begin
      if (ge) begin
        value_next = right_value;
      end
    end
  end

  always_comb begin
    hit_next = hit;
    if (ctrl.scan_clear) begin
      hit_next = 1'b0;
    end else if (ctrl.scan_run) begin
      hit_next = left_hit || eq;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= hit_next;
    end
  end

endmodule

// ===== test/mhpq_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the min-heap priority queue core: watches the command and
// result words, keeps its own heap and compares every result word field by field.
// Depends on mhpq_pkg.
module mhpq_result_checker #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  mhpq_pkg::cmd_word_t    cmd,
  input  logic                   done,
  input  mhpq_pkg::result_word_t result,
  output int unsigned            words_in_flight,
  output int unsigned            mismatches
);

  logic signed [mhpq_pkg::FIELD_WIDTH-1:0] heap_vals [CAPACITY];
  int unsigned heap_len;
  mhpq_pkg::result_word_t expected_words [$];
  int unsigned words_checked;

  function automatic void sift_up(input int unsigned from);
    int unsigned pos;
    int unsigned parent;
    logic signed [mhpq_pkg::FIELD_WIDTH-1:0] held;
    pos = from;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (heap_vals[parent] <= heap_vals[pos]) break;
      held = heap_vals[parent];
      heap_vals[parent] = heap_vals[pos];
      heap_vals[pos] = held;
      pos = parent;
    end
  endfunction

  // Applies one command word to the local heap and returns the result word due.
  function automatic mhpq_pkg::result_word_t apply_word(input mhpq_pkg::cmd_word_t w);
    mhpq_pkg::result_word_t r;
    mhpq_pkg::status_t st;
    int unsigned i;
    int unsigned hole;
    int unsigned pos;
    int unsigned best;
    int unsigned kid;
    logic signed [mhpq_pkg::FIELD_WIDTH-1:0] held;
    bit found;
    st = mhpq_pkg::ST_OK;
    found = 1'b0;
    hole = 0;
    case (w.action)
      mhpq_pkg::ACT_INSERT: begin
        if (heap_len >= CAPACITY) begin
          st = mhpq_pkg::ST_FULL;
        end else begin
          heap_vals[heap_len] = w.value;
          heap_len++;
          sift_up(heap_len - 1);
        end
      end
      mhpq_pkg::ACT_DELETE: begin
        for (i = 0; i < heap_len; i++) begin
          if (!found && heap_vals[i] == w.value) begin
            hole = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          st = mhpq_pkg::ST_NOT_FOUND;
        end else begin
          heap_len--;
          if (hole < heap_len) begin
            // last entry fills the hole, then goes down or up as needed
            heap_vals[hole] = heap_vals[heap_len];
            pos = hole;
            forever begin
              best = pos;
              kid = 2 * pos + 1;
              if (kid < heap_len && heap_vals[kid] < heap_vals[best]) best = kid;
              kid = 2 * pos + 2;
              if (kid < heap_len && heap_vals[kid] < heap_vals[best]) best = kid;
              if (best == pos) break;
              held = heap_vals[pos];
              heap_vals[pos] = heap_vals[best];
              heap_vals[best] = held;
              pos = best;
            end
            if (pos == hole) sift_up(hole);
          end
        end
      end
      mhpq_pkg::ACT_QUERY: begin
        if (heap_len == 0) st = mhpq_pkg::ST_EMPTY;
      end
      default: ;
    endcase
    r.min_value   = (heap_len > 0) ? heap_vals[0] : '0;
    r.entry_count = heap_len[mhpq_pkg::COUNT_WIDTH-1:0];
    r.status      = st;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t: result word %0d: %s is %0h, expected %0h",
             $realtime, words_checked, field, got, want);
  endtask

  always @(posedge clk) begin : watch
    mhpq_pkg::result_word_t want;
    if (rst) begin
      heap_len = 0;
      expected_words.delete();
      mismatches = 0;
      words_checked = 0;
    end else begin
      // result first: a new word may be taken at the edge that ends done
      if (done) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with none outstanding", 64'(result), 64'd0);
        end else begin
          want = expected_words.pop_front();
          if (result.min_value !== want.min_value)
            report_mismatch("min_value", 64'(result.min_value), 64'(want.min_value));
          if (result.entry_count !== want.entry_count)
            report_mismatch("entry_count", 64'(result.entry_count),
                            64'(want.entry_count));
          if (result.status !== want.status)
            report_mismatch("status", 64'(result.status), 64'(want.status));
        end
        words_checked++;
      end
      if (start && !busy) expected_words.insert(expected_words.size(), apply_word(cmd));
    end
    words_in_flight = expected_words.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the min-heap priority queue core testbench: clock, reset, command
// stimulus, watchdog and verdict. Depends on mhpq_pkg,
// min_heap_priority_queue_core and mhpq_result_checker.
module tb_top;

  localparam int unsigned CAPACITY = 1024;
  // slowest step: a delete scan after the longest sender gap, with margin
  localparam int unsigned STALL_LIMIT = 5 * (CAPACITY + 3 + 13);

  logic                   clk   = 1'b0;
  logic                   rst   = 1'b1;
  logic                   start = 1'b0;
  mhpq_pkg::cmd_word_t    cmd   = '0;
  logic                   busy;
  logic                   done;
  mhpq_pkg::result_word_t result;

  int unsigned words_in_flight;
  int unsigned mismatches;
  int unsigned quiet_cycles = 0;

  // Values believed held, for picking delete targets; stimulus only.
  logic signed [mhpq_pkg::FIELD_WIDTH-1:0] held_vals [$];
  bit idle_on = 1'b1;

  min_heap_priority_queue_core #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  mhpq_result_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .done           (done),
    .result         (result),
    .words_in_flight(words_in_flight),
    .mismatches     (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: any accepted word, in or out, restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Mix of extremes, a narrow band (plenty of duplicates) and full-range values.
  function automatic logic signed [mhpq_pkg::FIELD_WIDTH-1:0] pick_value();
    logic signed [mhpq_pkg::FIELD_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh7fff_ffff;
          1: v = 32'sh8000_0000;
          2: v = 32'sh0000_0000;
          3: v = 32'shffff_ffff;
          default: v = 32'sh0000_0001;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(0, 40)) - 20;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Mostly a value that is held, so deletes get past the search.
  function automatic logic signed [mhpq_pkg::FIELD_WIDTH-1:0] pick_victim();
    if (held_vals.size() > 0 && $urandom_range(0, 9) < 8)
      return held_vals[$urandom_range(0, held_vals.size() - 1)];
    return pick_value();
  endfunction

  // One command word: optional idle gap, then start held until taken.
  // start is only lowered when a gap follows, so back-to-back words keep it high.
  task automatic send_word(input mhpq_pkg::action_t act,
                           input logic signed [mhpq_pkg::FIELD_WIDTH-1:0] val);
    mhpq_pkg::cmd_word_t w;
    int unsigned gap;
    int idx;
    int i;
    if ($urandom_range(0, 29) == 0) idle_on = !idle_on;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.action = act;
    w.value  = val;
    start <= 1'b1;
    cmd   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (act)
      mhpq_pkg::ACT_INSERT: begin
        if (held_vals.size() < CAPACITY) held_vals.insert(held_vals.size(), val);
      end
      mhpq_pkg::ACT_DELETE: begin
        idx = -1;
        for (i = 0; i < held_vals.size(); i++)
          if (idx < 0 && held_vals[i] == val) idx = i;
        if (idx >= 0) held_vals.delete(idx);
      end
      default: ;
    endcase
  endtask

  // Weighted random word; weights in percent, the rest goes to no-ops.
  task automatic random_word(input int unsigned ins_w, input int unsigned del_w,
                             input int unsigned qry_w);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < ins_w) send_word(mhpq_pkg::ACT_INSERT, pick_value());
    else if (r < ins_w + del_w) send_word(mhpq_pkg::ACT_DELETE, pick_victim());
    else if (r < ins_w + del_w + qry_w) send_word(mhpq_pkg::ACT_QUERY, $urandom());
    else send_word(mhpq_pkg::ACT_NOP, $urandom());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // empty heap: query, delete, no-op
    send_word(mhpq_pkg::ACT_QUERY,  $urandom());
    send_word(mhpq_pkg::ACT_DELETE, 32'sh0000_0000);
    send_word(mhpq_pkg::ACT_NOP,    $urandom());
    // extremes of the value field
    send_word(mhpq_pkg::ACT_INSERT, 32'sh7fff_ffff);
    send_word(mhpq_pkg::ACT_INSERT, 32'sh8000_0000);
    send_word(mhpq_pkg::ACT_QUERY,  $urandom());
    send_word(mhpq_pkg::ACT_DELETE, 32'sh0000_0007);  // absent
    send_word(mhpq_pkg::ACT_DELETE, 32'sh8000_0000);  // the root
    send_word(mhpq_pkg::ACT_DELETE, 32'sh7fff_ffff);  // last entry, heap now empty
    // heap 0,10,1,11,12,2: deleting 11 moves 2 under 10, so it must go up
    send_word(mhpq_pkg::ACT_INSERT, 0);
    send_word(mhpq_pkg::ACT_INSERT, 10);
    send_word(mhpq_pkg::ACT_INSERT, 1);
    send_word(mhpq_pkg::ACT_INSERT, 11);
    send_word(mhpq_pkg::ACT_INSERT, 12);
    send_word(mhpq_pkg::ACT_INSERT, 2);
    send_word(mhpq_pkg::ACT_DELETE, 11);
    // duplicates: the first match goes, the copy stays
    send_word(mhpq_pkg::ACT_INSERT, 2);
    send_word(mhpq_pkg::ACT_DELETE, 2);
    send_word(mhpq_pkg::ACT_DELETE, 0);
    send_word(mhpq_pkg::ACT_INSERT, 32'shffff_ffff);
    send_word(mhpq_pkg::ACT_QUERY,  $urandom());
    send_word(mhpq_pkg::ACT_NOP,    $urandom());

    // --- random, small heap: growing, then draining back towards empty ---
    repeat (280) random_word(45, 35, 12);
    repeat (268) random_word(25, 55, 12);
    start <= 1'b0;

    // drain: sample on the falling edge, clear of the checker's update
    @(negedge clk);
    while (words_in_flight != 0) @(negedge clk);
    // long enough for a stray word after a full delete scan
    repeat (CAPACITY + 8) @(posedge clk);

    if (mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
